/* design/shg_pkg.sv */
package shg_pkg;

	// sizing of the grid
	localparam int MAX_SPOT_COUNT   = 256;
	localparam int BUCKET_COUNT     = 16;
	localparam int TILES_PER_BUCKET = 8;
	localparam int SPOTS_PER_TILE   = 8;

	// item field widths
	localparam int OP_W       = 2;
	localparam int POS_W      = 24;
	localparam int REACH_W    = 23;
	localparam int HANDLE_W   = 8;
	localparam int STATUS_W   = 3;
	localparam int TWID_W     = 13;
	localparam int TWID_RESET = 16;

	// fixed point and tile coordinate arithmetic
	localparam int FRAC_W   = 8;
	localparam int SUM_W    = POS_W + 1;
	localparam int TCOORD_W = SUM_W - FRAC_W;
	localparam int QUO_W    = TCOORD_W - 1;
	localparam int DIVCNT_W = $clog2(QUO_W);

	// derived storage widths
	localparam int SCOUNT_W   = $clog2(MAX_SPOT_COUNT + 1);
	localparam int BKT_W      = $clog2(BUCKET_COUNT);
	localparam int SLOT_W     = $clog2(TILES_PER_BUCKET);
	localparam int TILE_IDX_W = BKT_W + SLOT_W;
	localparam int MEMB_W     = $clog2(SPOTS_PER_TILE);
	localparam int BFILL_W    = $clog2(TILES_PER_BUCKET + 1);
	localparam int TFILL_W    = $clog2(SPOTS_PER_TILE + 1);
	localparam int TILE_COUNT = BUCKET_COUNT * TILES_PER_BUCKET;
	localparam int MEMB_COUNT = TILE_COUNT * SPOTS_PER_TILE;

	localparam logic [15:0] HASH_MASK_X = 16'hD555;
	localparam logic [15:0] HASH_MASK_Y = 16'h5555;

	typedef enum logic [OP_W-1:0] {
		OP_MAKE   = 2'd0,
		OP_LINK   = 2'd1,
		OP_UNLINK = 2'd2,
		OP_NOP    = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK          = 3'd0,
		ST_SPOTS_FULL  = 3'd1,
		ST_BAD_HANDLE  = 3'd2,
		ST_NOT_FOUND   = 3'd3,
		ST_BUCKET_FULL = 3'd4,
		ST_TILE_FULL   = 3'd5
	} status_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_DISPATCH,
		S_DIV_LOAD,
		S_DIV_STEP,
		S_DIV_STORE,
		S_SCAN,
		S_SCAN_CMP,
		S_FILL_RD,
		S_FILL_LD,
		S_TILE_OP,
		S_MEM_SCAN,
		S_MEM_CMP,
		S_SHIFT,
		S_SHIFT_WR,
		S_NEXT,
		S_DONE
	} ctrl_state_t;

	typedef struct packed {
		logic    cap_item;
		logic    spot_wr;
		logic    spot_rd;
		logic    div_load;
		logic    div_step;
		logic    div_store;
		logic    walk_init;
		logic    scan_rd;
		logic    scan_next;
		logic    tile_hit;
		logic    tile_make;
		logic    fill_rd;
		logic    fill_load;
		logic    link_wr;
		logic    mem_init;
		logic    mem_rd;
		logic    mem_next;
		logic    shift_rd;
		logic    shift_wr;
		logic    fill_dec;
		logic    step_x;
		logic    step_y;
		logic    out_load;
		status_t out_status;
	} shg_cmd_t;

	typedef struct packed {
		op_t  op;
		logic spots_full;
		logic bad_handle;
		logic div_last_step;
		logic div_last_op;
		logic scan_end;
		logic bucket_full;
		logic coord_match;
		logic tile_full;
		logic mem_end;
		logic mem_match;
		logic shift_end;
		logic x_end;
		logic y_end;
		logic out_free;
	} shg_sts_t;

endpackage

/* design/shg_req_if.sv */
interface shg_req_if import shg_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic [OP_W-1:0]            op;
	logic signed [POS_W-1:0]    spot_x;
	logic signed [POS_W-1:0]    spot_y;
	logic [HANDLE_W-1:0]        spot_handle;
	logic [REACH_W-1:0]         reach;

	modport source (output valid, op, spot_x, spot_y, spot_handle, reach, input ready);
	modport sink (input valid, op, spot_x, spot_y, spot_handle, reach, output ready);
endinterface

/* design/shg_rsp_if.sv */
interface shg_rsp_if import shg_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [STATUS_W-1:0]   status;
	logic [HANDLE_W-1:0]   new_handle;

	modport source (output valid, status, new_handle, input ready);
	modport sink (input valid, status, new_handle, output ready);
endinterface

/* design/shg_cfg_if.sv */
interface shg_cfg_if import shg_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [TWID_W-1:0]   tile_width;

	modport source (output valid, tile_width, input ready);
	modport sink (input valid, tile_width, output ready);
endinterface

/* design/shg_dpath.sv */
module shg_dpath import shg_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  shg_cmd_t                cmd,
	output shg_sts_t                sts,
	input  logic [OP_W-1:0]         op,
	input  logic signed [POS_W-1:0] spot_x,
	input  logic signed [POS_W-1:0] spot_y,
	input  logic [HANDLE_W-1:0]     spot_handle,
	input  logic [REACH_W-1:0]      reach,
	input  logic                    cfg_valid,
	input  logic [TWID_W-1:0]       cfg_tile_width,
	output logic                    rsp_valid,
	input  logic                    rsp_ready,
	output logic [STATUS_W-1:0]     rsp_status,
	output logic [HANDLE_W-1:0]     rsp_new_handle
);

	logic [TWID_W-1:0]          tile_width_q;
	op_t                        op_q;
	logic signed [POS_W-1:0]    sx_q, sy_q;
	logic [HANDLE_W-1:0]        h_q;
	logic [REACH_W-1:0]         reach_q;
	logic [SCOUNT_W-1:0]        spot_count_q;
	logic [HANDLE_W-1:0]        nh_q;

	logic [2*POS_W-1:0]         spot_mem [MAX_SPOT_COUNT];
	logic [2*POS_W-1:0]         spot_rd_q;

	logic [1:0]                 k_q;
	logic [DIVCNT_W-1:0]        dcnt_q;
	logic [QUO_W-1:0]           du_q;
	logic                       dneg_q;
	logic [TWID_W-1:0]          rem_q;

	logic signed [TCOORD_W-1:0] x0_q, x1_q, y0_q, y1_q, x_q, y_q;

	logic [BFILL_W-1:0]         bucket_fill_q [BUCKET_COUNT];
	logic [BFILL_W-1:0]         i_q;
	logic [TILE_IDX_W-1:0]      t_q;
	logic [TFILL_W-1:0]         n_q, j_q;

	logic [2*TCOORD_W-1:0]      coord_mem [TILE_COUNT];
	logic [2*TCOORD_W-1:0]      coord_rd_q;
	logic [TFILL_W-1:0]         fill_mem [TILE_COUNT];
	logic [TFILL_W-1:0]         fill_rd_q;
	logic [HANDLE_W-1:0]        memb_mem [MEMB_COUNT];
	logic [HANDLE_W-1:0]        memb_rd_q;

	logic                       rsp_valid_q;
	status_t                    rsp_status_q;
	logic [HANDLE_W-1:0]        rsp_nh_q;

	logic [TWID_W-1:0]          twe;
	logic [POS_W-1:0]           pos_sel;
	logic [SUM_W-1:0]           pos_ext, r_ext, dvd;
	logic [TCOORD_W-1:0]        dvd_fl;
	logic                       dvd_neg;
	logic [QUO_W-1:0]           dvd_mag;
	logic [TWID_W:0]            trial, rem_nx;
	logic                       ge;
	logic [TCOORD_W-1:0]        quo_signed;
	logic [15:0]                hx, hy;
	logic [16:0]                hv;
	logic [BKT_W-1:0]           bkt;
	logic [BFILL_W-1:0]         cur_bfill;
	logic [TILE_IDX_W-1:0]      scan_addr, make_slot;
	logic [TFILL_W-1:0]         j_inc;
	logic                       fill_we;
	logic [TILE_IDX_W-1:0]      fill_wa;
	logic [TFILL_W-1:0]         fill_wd;
	logic                       memb_we;
	logic [MEMB_W-1:0]          memb_wslot;
	logic [HANDLE_W-1:0]        memb_wd;
	logic [MEMB_W-1:0]          memb_rslot;

	// floor division arithmetic
	assign twe     = (tile_width_q == '0) ? TWID_W'(1) : tile_width_q;
	assign pos_sel = k_q[1] ? spot_rd_q[POS_W-1:0] : spot_rd_q[2*POS_W-1:POS_W];
	assign pos_ext = {pos_sel[POS_W-1], pos_sel};
	assign r_ext   = {2'b00, reach_q};
	assign dvd     = k_q[0] ? (pos_ext + r_ext) : (pos_ext - r_ext);
	assign dvd_fl  = dvd[SUM_W-1:FRAC_W];
	assign dvd_neg = dvd_fl[TCOORD_W-1];
	assign dvd_mag = dvd_neg ? ~dvd_fl[QUO_W-1:0] : dvd_fl[QUO_W-1:0];
	assign trial   = {rem_q, du_q[QUO_W-1]};
	assign ge      = trial >= {1'b0, twe};
	assign rem_nx  = ge ? (trial - {1'b0, twe}) : trial;
	assign quo_signed = dneg_q ? ~{1'b0, du_q} : {1'b0, du_q};

	// bucket hash on the low tile coordinate bits
	assign hx        = x_q[15:0] & HASH_MASK_X;
	assign hy        = y_q[15:0] & HASH_MASK_Y;
	assign hv        = {hx, 1'b0} | {1'b0, hy};
	assign bkt       = hv[BKT_W-1:0];
	assign cur_bfill = bucket_fill_q[bkt];
	assign scan_addr = {bkt, i_q[SLOT_W-1:0]};
	assign make_slot = {bkt, cur_bfill[SLOT_W-1:0]};
	assign j_inc     = j_q + 1'b1;

	always_comb begin
		sts.op            = op_q;
		sts.spots_full    = spot_count_q == SCOUNT_W'(MAX_SPOT_COUNT);
		sts.bad_handle    = {1'b0, h_q} >= spot_count_q;
		sts.div_last_step = dcnt_q == DIVCNT_W'(QUO_W - 1);
		sts.div_last_op   = k_q == 2'd3;
		sts.scan_end      = i_q == cur_bfill;
		sts.bucket_full   = cur_bfill >= BFILL_W'(TILES_PER_BUCKET);
		sts.coord_match   = coord_rd_q == {x_q, y_q};
		sts.tile_full     = n_q >= TFILL_W'(SPOTS_PER_TILE);
		sts.mem_end       = j_q == n_q;
		sts.mem_match     = memb_rd_q == h_q;
		sts.shift_end     = j_inc >= n_q;
		sts.x_end         = x_q == x1_q;
		sts.y_end         = y_q == y1_q;
		sts.out_free      = !rsp_valid_q || rsp_ready;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tile_width_q <= TWID_W'(TWID_RESET);
			spot_count_q <= '0;
			rsp_valid_q  <= 1'b0;
			for (int b = 0; b < BUCKET_COUNT; b++) begin
				bucket_fill_q[b] <= '0;
			end
		end else begin
			if (cfg_valid) begin
				tile_width_q <= cfg_tile_width;
			end
			if (cmd.spot_wr) begin
				spot_count_q <= spot_count_q + 1'b1;
			end
			if (cmd.tile_make) begin
				bucket_fill_q[bkt] <= cur_bfill + 1'b1;
			end
			if (cmd.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload and working registers
	always_ff @(posedge clk) begin
		if (cmd.cap_item) begin
			op_q    <= op_t'(op);
			sx_q    <= spot_x;
			sy_q    <= spot_y;
			h_q     <= spot_handle;
			reach_q <= reach;
			nh_q    <= '0;
		end
		if (cmd.spot_wr) begin
			nh_q <= spot_count_q[HANDLE_W-1:0];
		end
		if (cmd.div_load) begin
			du_q   <= dvd_mag;
			dneg_q <= dvd_neg;
			rem_q  <= '0;
			dcnt_q <= '0;
		end
		if (cmd.div_step) begin
			du_q   <= {du_q[QUO_W-2:0], ge};
			rem_q  <= rem_nx[TWID_W-1:0];
			dcnt_q <= dcnt_q + 1'b1;
		end
		if (cmd.spot_rd) begin
			k_q <= '0;
		end
		if (cmd.div_store) begin
			unique case (k_q)
				2'd0: x0_q <= quo_signed;
				2'd1: x1_q <= quo_signed;
				2'd2: y0_q <= quo_signed;
				default: y1_q <= quo_signed;
			endcase
			k_q <= k_q + 1'b1;
		end
		if (cmd.walk_init) begin
			x_q <= x0_q;
			y_q <= y0_q;
			i_q <= '0;
		end
		if (cmd.step_x) begin
			x_q <= x_q + 1'b1;
			i_q <= '0;
		end
		if (cmd.step_y) begin
			x_q <= x0_q;
			y_q <= y_q + 1'b1;
			i_q <= '0;
		end
		if (cmd.scan_next) begin
			i_q <= i_q + 1'b1;
		end
		if (cmd.tile_hit) begin
			t_q <= scan_addr;
		end
		if (cmd.tile_make) begin
			t_q <= make_slot;
			n_q <= '0;
		end
		if (cmd.fill_load) begin
			n_q <= fill_rd_q;
		end
		if (cmd.mem_init) begin
			j_q <= '0;
		end
		if (cmd.mem_next || cmd.shift_wr) begin
			j_q <= j_inc;
		end
		if (cmd.out_load) begin
			rsp_status_q <= cmd.out_status;
			rsp_nh_q     <= nh_q;
		end
	end

	// write port selection
	always_comb begin
		fill_we = cmd.tile_make || cmd.link_wr || cmd.fill_dec;
		fill_wa = cmd.tile_make ? make_slot : t_q;
		priority if (cmd.tile_make) begin
			fill_wd = '0;
		end else if (cmd.link_wr) begin
			fill_wd = n_q + 1'b1;
		end else begin
			fill_wd = n_q - 1'b1;
		end
		memb_we    = cmd.link_wr || cmd.shift_wr;
		memb_wslot = cmd.link_wr ? n_q[MEMB_W-1:0] : j_q[MEMB_W-1:0];
		memb_wd    = cmd.link_wr ? h_q : memb_rd_q;
		memb_rslot = cmd.shift_rd ? j_inc[MEMB_W-1:0] : j_q[MEMB_W-1:0];
	end

	// memories
	always_ff @(posedge clk) begin
		if (cmd.spot_wr) begin
			spot_mem[spot_count_q[HANDLE_W-1:0]] <= {sx_q, sy_q};
		end
		if (cmd.spot_rd) begin
			spot_rd_q <= spot_mem[h_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.tile_make) begin
			coord_mem[make_slot] <= {x_q, y_q};
		end
		if (cmd.scan_rd) begin
			coord_rd_q <= coord_mem[scan_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (fill_we) begin
			fill_mem[fill_wa] <= fill_wd;
		end
		if (cmd.fill_rd) begin
			fill_rd_q <= fill_mem[t_q];
		end
	end

	always_ff @(posedge clk) begin
		if (memb_we) begin
			memb_mem[{t_q, memb_wslot}] <= memb_wd;
		end
		if (cmd.mem_rd || cmd.shift_rd) begin
			memb_rd_q <= memb_mem[{t_q, memb_rslot}];
		end
	end

	assign rsp_valid      = rsp_valid_q;
	assign rsp_status     = rsp_status_q;
	assign rsp_new_handle = rsp_nh_q;

`ifndef NO_ASSERTIONS
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.spot_wr |=> spot_count_q == SCOUNT_W'($past(spot_count_q) + 1'b1))
		else $error("spot count did not advance on make");
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		spot_count_q <= SCOUNT_W'(MAX_SPOT_COUNT))
		else $error("spot count beyond capacity");
	a_make_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.tile_make |-> cur_bfill < BFILL_W'(TILES_PER_BUCKET))
		else $error("tile created in a full bucket");
	a_link_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.link_wr |-> n_q < TFILL_W'(SPOTS_PER_TILE))
		else $error("member appended to a full tile");
`endif

endmodule

/* design/shg_ctrl.sv */
module shg_ctrl import shg_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  shg_sts_t sts,
	output shg_cmd_t cmd
);

	ctrl_state_t state_q, state_d;
	status_t     res_q, res_d;
	logic        is_link;

	assign is_link  = sts.op == OP_LINK;
	assign in_ready = state_q == S_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			res_q   <= ST_OK;
		end else begin
			state_q <= state_d;
			res_q   <= res_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_DISPATCH;
			end
			S_DISPATCH: begin
				unique case (sts.op)
					OP_LINK, OP_UNLINK: state_d = sts.bad_handle ? S_DONE : S_DIV_LOAD;
					default: state_d = S_DONE;
				endcase
			end
			S_DIV_LOAD: state_d = S_DIV_STEP;
			S_DIV_STEP: begin
				if (sts.div_last_step) state_d = S_DIV_STORE;
			end
			S_DIV_STORE: state_d = sts.div_last_op ? S_SCAN : S_DIV_LOAD;
			S_SCAN: begin
				priority if (!sts.scan_end) state_d = S_SCAN_CMP;
				else if (sts.bucket_full) state_d = S_DONE;
				else state_d = S_TILE_OP;
			end
			S_SCAN_CMP: state_d = sts.coord_match ? S_FILL_RD : S_SCAN;
			S_FILL_RD:  state_d = S_FILL_LD;
			S_FILL_LD:  state_d = S_TILE_OP;
			S_TILE_OP: begin
				priority if (!is_link) state_d = S_MEM_SCAN;
				else if (sts.tile_full) state_d = S_DONE;
				else state_d = S_NEXT;
			end
			S_MEM_SCAN: state_d = sts.mem_end ? S_DONE : S_MEM_CMP;
			S_MEM_CMP:  state_d = sts.mem_match ? S_SHIFT : S_MEM_SCAN;
			S_SHIFT:    state_d = sts.shift_end ? S_NEXT : S_SHIFT_WR;
			S_SHIFT_WR: state_d = S_SHIFT;
			S_NEXT:     state_d = (sts.x_end && sts.y_end) ? S_DONE : S_SCAN;
			S_DONE: begin
				if (sts.out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd            = '0;
		cmd.out_status = res_q;
		res_d          = res_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.cap_item = 1'b1;
					res_d        = ST_OK;
				end
			end
			S_DISPATCH: begin
				unique case (sts.op)
					OP_MAKE: begin
						if (sts.spots_full) res_d = ST_SPOTS_FULL;
						else cmd.spot_wr = 1'b1;
					end
					OP_LINK, OP_UNLINK: begin
						if (sts.bad_handle) res_d = ST_BAD_HANDLE;
						else cmd.spot_rd = 1'b1;
					end
					default: ;
				endcase
			end
			S_DIV_LOAD: cmd.div_load = 1'b1;
			S_DIV_STEP: cmd.div_step = 1'b1;
			S_DIV_STORE: begin
				cmd.div_store = 1'b1;
				cmd.walk_init = sts.div_last_op;
			end
			S_SCAN: begin
				priority if (!sts.scan_end) cmd.scan_rd = 1'b1;
				else if (sts.bucket_full) res_d = ST_BUCKET_FULL;
				else cmd.tile_make = 1'b1;
			end
			S_SCAN_CMP: begin
				cmd.tile_hit  = sts.coord_match;
				cmd.scan_next = !sts.coord_match;
			end
			S_FILL_RD: cmd.fill_rd = 1'b1;
			S_FILL_LD: cmd.fill_load = 1'b1;
			S_TILE_OP: begin
				priority if (!is_link) cmd.mem_init = 1'b1;
				else if (sts.tile_full) res_d = ST_TILE_FULL;
				else cmd.link_wr = 1'b1;
			end
			S_MEM_SCAN: begin
				if (sts.mem_end) res_d = ST_NOT_FOUND;
				else cmd.mem_rd = 1'b1;
			end
			S_MEM_CMP: cmd.mem_next = !sts.mem_match;
			S_SHIFT: begin
				cmd.fill_dec = sts.shift_end;
				cmd.shift_rd = !sts.shift_end;
			end
			S_SHIFT_WR: cmd.shift_wr = 1'b1;
			S_NEXT: begin
				cmd.step_x = !sts.x_end;
				cmd.step_y = sts.x_end && !sts.y_end;
			end
			S_DONE: cmd.out_load = sts.out_free;
			default: ;
		endcase
	end

`ifndef NO_ASSERTIONS
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("result loaded over an untaken result");
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cap_item |=> state_q == S_DISPATCH)
		else $error("accepted item not dispatched");
	a_walk_err: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_NEXT && state_d == S_SCAN) |-> res_q == ST_OK)
		else $error("walk continued after an error");
`endif

endmodule

/* design/spatial_hash_grid_link_core.sv */
// spatial hash grid over square tiles: a make item stores a spot position and returns its
// handle, a link item appends the spot to every tile its reach square touches and an unlink
// item removes it again, each tile being found or created in a bucket picked by a masked hash
// of its tile coordinates; one result item comes back per input item and the next item is
// taken as soon as the previous one has finished, even while its result still waits on rsp;
// a link or unlink first runs four floor divisions (one quotient bit a cycle through a shared
// 13-bit restoring divider, 16 quotient bits each plus a load and a store step) and then,
// per covered tile, compares bucket entries, fetches or creates the tile and, on unlink,
// searches the members, shifts each later member down and writes back the fill; the grid
// needs no clearing pass after reset
module spatial_hash_grid_link_core import shg_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	shg_req_if.sink   req,
	shg_rsp_if.source rsp,
	shg_cfg_if.sink   cfg
);

	shg_cmd_t cmd;
	shg_sts_t sts;

	// tile width register is always writable
	assign cfg.ready = 1'b1;

	// sequencer: accepts one item, walks it, hands the result to the output register
	shg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// divider, walk counters, spot and tile memories, result register
	shg_dpath u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.op             (req.op),
		.spot_x         (req.spot_x),
		.spot_y         (req.spot_y),
		.spot_handle    (req.spot_handle),
		.reach          (req.reach),
		.cfg_valid      (cfg.valid),
		.cfg_tile_width (cfg.tile_width),
		.rsp_valid      (rsp.valid),
		.rsp_ready      (rsp.ready),
		.rsp_status     (rsp.status),
		.rsp_new_handle (rsp.new_handle)
	);

endmodule
